// File: src/positional_list_engine_defines.svh
// assertion macros shared by the positional list engine
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define PLE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed in %m");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define PLE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed in %m");

`endif

// File: src/ple_pkg.sv
// shared types and constants of the positional list engine
package ple_pkg;

  localparam int MODE_W      = 3;
  localparam int POS_W       = 6;
  localparam int DATA_W      = 32;
  localparam int STATUS_W    = 3;
  localparam int QUEUE_DEPTH = 2;

  // command codes on the input channel
  typedef enum logic [MODE_W-1:0] {
    MODE_EMPTY_Q   = 3'd0,
    MODE_INSERT    = 3'd1,
    MODE_ERASE     = 3'd2,
    MODE_FIND      = 3'd3,
    MODE_PRINT_FWD = 3'd4,
    MODE_PRINT_BWD = 3'd5
  } mode_e;

  // result codes on the output channel
  typedef enum logic [STATUS_W-1:0] {
    ST_ELEMENT   = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_RANGE     = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_TRUE      = 3'd5,
    ST_FALSE     = 3'd6,
    ST_FULL      = 3'd7
  } status_e;

  // decoded operation handed from the front to the back
  typedef enum logic [2:0] {
    OP_QUERY  = 3'd0,
    OP_INSERT = 3'd1,
    OP_ERASE  = 3'd2,
    OP_FIND   = 3'd3,
    OP_PRINT  = 3'd4
  } op_e;

  typedef struct packed {
    op_e               op;
    logic              backward;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] value;
  } cmd_t;

endpackage

// File: src/ple_if.sv
// command and response channel interfaces of the positional list engine
interface ple_cmd_if;
  logic                                valid;
  logic                                ready;
  logic        [ple_pkg::MODE_W-1:0]   mode;
  logic        [ple_pkg::POS_W-1:0]    position;
  logic signed [ple_pkg::DATA_W-1:0]   value;

  modport source (output valid, mode, position, value, input ready);
  modport sink   (input valid, mode, position, value, output ready);
endinterface

interface ple_rsp_if;
  logic                                valid;
  logic                                ready;
  logic        [ple_pkg::STATUS_W-1:0] status;
  logic signed [ple_pkg::DATA_W-1:0]   payload;
  logic                                last;

  modport source (output valid, status, payload, last, input ready);
  modport sink   (input valid, status, payload, last, output ready);
endinterface

// File: src/positional_list_engine.sv
// positional list engine: ordered list of signed 32-bit values, one command per beat
// answers: a one-beat answer passes through the queue and the response register; a walk
//   runs its element steps first, and a busy response register holds the answer back
// walks: each element visited is read, then used; insert shifts the tail up, then writes
//   its value; erase shifts the later ones down; find checks and print emits each element
// reset: rst_ni clears the count, queue and response valid flag; stored values stay
`include "positional_list_engine_defines.svh"

module positional_list_engine import ple_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ple_cmd_if.sink    cmd_i,
  ple_rsp_if.source  rsp_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // decoded commands, front to queue
  logic             push_valid;
  logic             push_ready;
  cmd_t             push_cmd;

  // queue to engine
  logic             pop_valid;
  logic             pop_ready;
  cmd_t             pop_cmd;

  // current list length, for checking
  logic [CNT_W-1:0] count_w;

  // front: classify the mode, drop codes with no meaning
  ple_front u_front (
    .cmd_i        (cmd_i),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd)
  );

  // two-deep queue lets the front keep taking beats during a long walk
  ple_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_ready_i  (pop_ready)
  );

  // back: bound checks, element walks and the response register
  ple_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_cmd_i   (pop_cmd),
    .pop_ready_o (pop_ready),
    .rsp_o       (rsp_o),
    .count_o     (count_w)
  );

  // the list never grows past its capacity
  `PLE_ASSERT_IMP(a_count_bound, 1'b1, count_w <= CNT_W'(CAPACITY))

  // any change of the length is a step of exactly one element
  `PLE_ASSERT_IMP(a_count_step, !$stable(count_w),
    (count_w == $past(count_w) + CNT_W'(1)) || (count_w == $past(count_w) - CNT_W'(1)))

  // every non-element answer is the only beat of its command
  `PLE_ASSERT_IMP(a_single_last, rsp_o.valid && (rsp_o.status != ST_ELEMENT), rsp_o.last)

endmodule

// File: src/ple_front.sv
// command decoder: classifies incoming beats and drops unused modes
module ple_front import ple_pkg::*; (
  ple_cmd_if.sink cmd_i,
  input  logic    push_ready_i,
  output logic    push_valid_o,
  output cmd_t    push_cmd_o
);

  logic legal;
  op_e  op;
  logic backward;

  always_comb begin
    legal    = 1'b1;
    op       = OP_QUERY;
    backward = 1'b0;
    unique case (mode_e'(cmd_i.mode))
      MODE_EMPTY_Q:   op = OP_QUERY;
      MODE_INSERT:    op = OP_INSERT;
      MODE_ERASE:     op = OP_ERASE;
      MODE_FIND:      op = OP_FIND;
      MODE_PRINT_FWD: op = OP_PRINT;
      MODE_PRINT_BWD: begin
        op       = OP_PRINT;
        backward = 1'b1;
      end
      default:        legal = 1'b0;
    endcase
  end

  // unused modes are taken and discarded
  assign cmd_i.ready           = push_ready_i;
  assign push_valid_o          = cmd_i.valid && legal;
  assign push_cmd_o.op         = op;
  assign push_cmd_o.backward   = backward;
  assign push_cmd_o.position   = cmd_i.position;
  assign push_cmd_o.value      = cmd_i.value;

endmodule

// File: src/ple_queue.sv
// small command queue between the decoder and the list engine
module ple_queue import ple_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  cmd_t push_cmd_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output cmd_t pop_cmd_o,
  input  logic pop_ready_i
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FW-1:0] fill_q, fill_d;
  logic          push, pop;

  assign push_ready_o = fill_q != FW'(QUEUE_DEPTH);
  assign pop_valid_o  = fill_q != '0;
  assign pop_cmd_o    = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      fill_d = fill_q + FW'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - FW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// File: src/ple_back.sv
// list engine: element memory, walk sequencer and response register
module ple_back import ple_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               pop_valid_i,
  input  cmd_t                               pop_cmd_i,
  output logic                               pop_ready_o,
  ple_rsp_if.source                          rsp_o,
  output logic [$clog2(CAPACITY + 1)-1:0]    count_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_READ    = 6'b000010,
    S_SHIFT   = 6'b000100,
    S_INS_FIN = 6'b001000,
    S_CHECK   = 6'b010000,
    S_EMIT    = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  cmd_t              cmd_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  j_q, j_d;
  logic [CNT_W-1:0]  count_last, cur_pos, raddr_full;
  logic [CW-1:0]     head_pos_w, count_w;

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] wdata;

  logic              out_free, emit, emit_last;
  status_e           emit_status;
  logic [DATA_W-1:0] emit_payload;
  logic              out_valid_q, out_last_q;
  status_e           out_status_q;
  logic [DATA_W-1:0] out_payload_q;

  assign count_last = count_q - CNT_W'(1);
  assign cur_pos    = CNT_W'(cmd_q.position);
  assign head_pos_w = CW'(pop_cmd_i.position);
  assign count_w    = CW'(count_q);
  assign out_free   = !out_valid_q || rsp_o.ready;

  // read address of the current walk step
  always_comb begin
    unique case (cmd_q.op)
      OP_INSERT: raddr_full = j_q - CNT_W'(1);
      OP_ERASE:  raddr_full = j_q + CNT_W'(1);
      OP_FIND:   raddr_full = count_last - j_q;
      OP_PRINT:  raddr_full = cmd_q.backward ? count_last - j_q : j_q;
      default:   raddr_full = j_q;
    endcase
  end

  assign raddr  = raddr_full[AW-1:0];
  assign mem_re = state_q == S_READ;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    j_d          = j_q;
    mem_we       = 1'b0;
    waddr        = j_q[AW-1:0];
    wdata        = rdata_q;
    emit         = 1'b0;
    emit_status  = ST_ELEMENT;
    emit_payload = '0;
    emit_last    = 1'b1;
    pop_ready_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        pop_ready_o = out_free;
        if (pop_valid_i && out_free) begin
          unique case (pop_cmd_i.op)
            OP_QUERY: begin
              emit        = 1'b1;
              emit_status = (count_q == '0) ? ST_TRUE : ST_FALSE;
            end
            OP_INSERT: begin
              if (head_pos_w > count_w) begin
                emit        = 1'b1;
                emit_status = ST_RANGE;
              end else if (count_q == CNT_W'(CAPACITY)) begin
                emit        = 1'b1;
                emit_status = ST_FULL;
              end else begin
                j_d     = count_q;
                state_d = (head_pos_w == count_w) ? S_INS_FIN : S_READ;
              end
            end
            OP_ERASE: begin
              if (head_pos_w >= count_w) begin
                emit        = 1'b1;
                emit_status = ST_RANGE;
              end else begin
                j_d = CNT_W'(pop_cmd_i.position);
                if (head_pos_w + CW'(1) == count_w) begin
                  count_d = count_last;
                end else begin
                  state_d = S_READ;
                end
              end
            end
            OP_FIND: begin
              if (count_q == '0) begin
                emit        = 1'b1;
                emit_status = ST_NOT_FOUND;
              end else begin
                j_d     = '0;
                state_d = S_READ;
              end
            end
            OP_PRINT: begin
              if (count_q == '0) begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
              end else begin
                j_d     = '0;
                state_d = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (cmd_q.op == OP_INSERT || cmd_q.op == OP_ERASE) begin
          state_d = S_SHIFT;
        end else if (cmd_q.op == OP_FIND) begin
          state_d = S_CHECK;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_SHIFT: begin
        mem_we = 1'b1;
        if (cmd_q.op == OP_INSERT) begin
          j_d     = j_q - CNT_W'(1);
          state_d = (j_q - CNT_W'(1) == cur_pos) ? S_INS_FIN : S_READ;
        end else if (j_q + CNT_W'(2) == count_q) begin
          count_d = count_last;
          state_d = S_IDLE;
        end else begin
          j_d     = j_q + CNT_W'(1);
          state_d = S_READ;
        end
      end
      S_INS_FIN: begin
        mem_we  = 1'b1;
        waddr   = cur_pos[AW-1:0];
        wdata   = cmd_q.value;
        count_d = count_q + CNT_W'(1);
        state_d = S_IDLE;
      end
      S_CHECK: begin
        if (rdata_q == cmd_q.value) begin
          if (out_free) begin
            emit         = 1'b1;
            emit_status  = ST_FOUND;
            emit_payload = DATA_W'(j_q);
            state_d      = S_IDLE;
          end
        end else if (j_q == count_last) begin
          if (out_free) begin
            emit        = 1'b1;
            emit_status = ST_NOT_FOUND;
            state_d     = S_IDLE;
          end
        end else begin
          j_d     = j_q + CNT_W'(1);
          state_d = S_READ;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          emit         = 1'b1;
          emit_status  = ST_ELEMENT;
          emit_payload = rdata_q;
          emit_last    = j_q == count_last;
          if (j_q == count_last) begin
            state_d = S_IDLE;
          end else begin
            j_d     = j_q + CNT_W'(1);
            state_d = S_READ;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      j_q     <= j_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_valid_i && pop_ready_o) begin
      cmd_q <= pop_cmd_i;
    end
    if (emit) begin
      out_status_q  <= emit_status;
      out_payload_q <= emit_payload;
      out_last_q    <= emit_last;
    end
  end

  // element store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.status  = out_status_q;
  assign rsp_o.payload = out_payload_q;
  assign rsp_o.last    = out_last_q;
  assign count_o       = count_q;

endmodule
